// File: sv/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, codes and constants for the integer-to-ASCII formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

  localparam int unsigned MAX_WIDTH   = 63;
  localparam int unsigned DIGIT_DEPTH = 32;
  localparam int unsigned DIG_AW      = $clog2(DIGIT_DEPTH);
  localparam int unsigned CNT_W       = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DCNT_W      = $clog2(DIGIT_DEPTH + 1);

  // conversion kinds on the action field
  localparam logic [2:0] ACT_SDEC = 3'd0;
  localparam logic [2:0] ACT_UDEC = 3'd1;
  localparam logic [2:0] ACT_OCT  = 3'd2;
  localparam logic [2:0] ACT_HEXL = 3'd3;
  localparam logic [2:0] ACT_HEXU = 3'd4;
  localparam logic [2:0] ACT_BIN  = 3'd5;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;

  // 2^35 / 10 rounded up: exact quotient for every 32-bit dividend
  localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
  localparam int unsigned DEC_SHIFT = 35;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_OCT,
    BASE_HEX,
    BASE_BIN
  } base_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_e;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] d8;
    d8 = {4'd0, d};
    if (d < 4'd10) begin
      digit_char = CH_ZERO + d8;
    end else if (upper) begin
      digit_char = CH_UA + d8 - 8'd10;
    end else begin
      digit_char = CH_LA + d8 - 8'd10;
    end
  endfunction

endpackage

`default_nettype wire

// File: sv/itoa_digit_unit.sv
// ----------------------------------------------------------------------------
// itoa_digit_unit
// One digit step: splits the dividend into quotient and low digit for the
// selected base. Decimal uses a reciprocal multiply, the others shift.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_digit_unit (
  input  logic [31:0]           dividend_i,
  input  itoa_pkg::base_e       base_i,
  output logic [31:0]           quot_o,
  output logic [3:0]            rem_o
);

  logic [63:0] prod;
  logic [31:0] dec_quot;
  logic [31:0] dec_rem;

  assign prod     = {32'd0, dividend_i} * {32'd0, itoa_pkg::DEC_RECIP};
  assign dec_quot = 32'(prod >> itoa_pkg::DEC_SHIFT);
  // q*10 = q*8 + q*2
  assign dec_rem  = dividend_i - ((dec_quot << 3) + (dec_quot << 1));

  always_comb begin
    case (base_i)
      itoa_pkg::BASE_DEC: begin
        quot_o = dec_quot;
        rem_o  = dec_rem[3:0];
      end
      itoa_pkg::BASE_OCT: begin
        quot_o = dividend_i >> 3;
        rem_o  = {1'b0, dividend_i[2:0]};
      end
      itoa_pkg::BASE_HEX: begin
        quot_o = dividend_i >> 4;
        rem_o  = dividend_i[3:0];
      end
      default: begin
        quot_o = dividend_i >> 1;
        rem_o  = {3'd0, dividend_i[0]};
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// printf-style integer conversion: signed/unsigned decimal, octal, hex and
// binary with field width; all but binary also take precision and left justification.
// ----------------------------------------------------------------------------
// Flow: an item is accepted, then ST_CONV makes one digit per cycle (none for zero,
// up to 10 decimal, 11 octal, 8 hex, 32 binary), then ST_EMIT registers one character
// per beat while the output is not stalled. Work is set by the single digit unit and
// the one-character output register.
// Input is stalled while an item is in work. Reset clears all control state;
// the digit store is not reset.
`default_nettype none

module integer_to_ascii_formatter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [31:0]       value_i,
  input  logic [2:0]        action_i,
  input  logic [5:0]        field_width_i,
  input  logic signed [6:0] min_digits_i,
  input  logic              left_align_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_char_o,
  output logic              last_o
);

  localparam int unsigned CW  = itoa_pkg::CNT_W;
  localparam int unsigned DW  = itoa_pkg::DCNT_W;
  localparam int unsigned AW  = itoa_pkg::DIG_AW;

  itoa_pkg::state_e state_q, state_d;

  // item registers
  logic              neg_q;
  logic              upper_q;
  logic              left_q;
  logic              prec_en_q;
  logic [CW-1:0]     prec_q;
  logic [CW-1:0]     fw_q;
  itoa_pkg::base_e   base_q;
  logic [31:0]       rq_q;
  logic [DW-1:0]     dc_q;
  logic [CW-1:0]     pos_q;
  logic [3:0]        digit_store [itoa_pkg::DIGIT_DEPTH];

  logic              out_valid_q;
  logic [7:0]        out_char_q;
  logic              last_q;

  // decoded input
  itoa_pkg::base_e   in_base;
  logic              in_upper;
  logic              in_neg;
  logic              in_left;
  logic              in_prec_en;
  logic [CW-1:0]     in_prec;
  logic [31:0]       in_mag;

  // control strobes
  logic              accept;
  logic              conv_step;
  logic              emit_beat;
  logic              out_free;

  logic [31:0]       quot;
  logic [3:0]        rem;

  // sizes
  logic [CW-1:0]     dc_w;
  logic [CW-1:0]     zeros;
  logic [CW-1:0]     body;
  logic [CW-1:0]     pad;
  logic [CW-1:0]     total;
  logic [CW-1:0]     p;
  logic [CW-1:0]     q;
  logic [CW-1:0]     didx;
  logic              in_pad;
  logic [7:0]        ch;
  logic              is_last;

  // ---------------------------------------------------------------- decode
  always_comb begin
    in_base    = itoa_pkg::BASE_DEC;
    in_upper   = 1'b0;
    in_left    = left_align_i;
    in_prec_en = !min_digits_i[6];
    case (action_i)
      itoa_pkg::ACT_OCT:  in_base = itoa_pkg::BASE_OCT;
      itoa_pkg::ACT_HEXL: in_base = itoa_pkg::BASE_HEX;
      itoa_pkg::ACT_HEXU: begin
        in_base  = itoa_pkg::BASE_HEX;
        in_upper = 1'b1;
      end
      itoa_pkg::ACT_BIN: begin
        in_base    = itoa_pkg::BASE_BIN;
        in_left    = 1'b0;
        in_prec_en = 1'b0;
      end
      default: in_base = itoa_pkg::BASE_DEC;
    endcase
    // precision saturates at MAX_WIDTH-1
    if (min_digits_i[5:0] > CW'(itoa_pkg::MAX_WIDTH - 1)) begin
      in_prec = CW'(itoa_pkg::MAX_WIDTH - 1);
    end else begin
      in_prec = CW'(min_digits_i[5:0]);
    end
    in_neg = (action_i == itoa_pkg::ACT_SDEC) && value_i[31];
    in_mag = in_neg ? (32'd0 - value_i) : value_i;
  end

  itoa_digit_unit u_digit (
    .dividend_i (rq_q),
    .base_i     (base_q),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // ---------------------------------------------------------------- sizes
  always_comb begin
    dc_w  = CW'(dc_q);
    zeros = (prec_en_q && (prec_q > dc_w)) ? (prec_q - dc_w) : '0;
    body  = CW'({1'b0, zeros} + {1'b0, dc_w} + (CW+1)'(neg_q));
    pad   = (fw_q > body) ? (fw_q - body) : '0;
    total = (fw_q > body) ? fw_q : body;

    if (left_q) begin
      p      = pos_q;
      in_pad = (pos_q >= body);
    end else begin
      p      = pos_q - pad;
      in_pad = (pos_q < pad);
    end
    q    = p - CW'(neg_q);
    didx = dc_w - CW'(1) - (q - zeros);

    if (in_pad) begin
      ch = itoa_pkg::CH_SPACE;
    end else if (neg_q && (p == '0)) begin
      ch = itoa_pkg::CH_MINUS;
    end else if (q < zeros) begin
      ch = itoa_pkg::CH_ZERO;
    end else begin
      ch = itoa_pkg::digit_char(digit_store[didx[AW-1:0]], upper_q);
    end
    is_last = (pos_q == total - CW'(1));
  end

  // ---------------------------------------------------------------- FSM
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != itoa_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      itoa_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_mag == 32'd0) ? itoa_pkg::ST_EMIT : itoa_pkg::ST_CONV;
        end
      end
      itoa_pkg::ST_CONV: begin
        if ((quot == 32'd0) || (dc_q == DW'(itoa_pkg::DIGIT_DEPTH - 1))) begin
          state_d = itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_EMIT: begin
        if (total == '0) begin
          state_d = itoa_pkg::ST_IDLE;
        end else if (out_free && is_last) begin
          state_d = itoa_pkg::ST_IDLE;
        end
      end
      default: state_d = itoa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    accept    = 1'b0;
    conv_step = 1'b0;
    emit_beat = 1'b0;
    case (state_q)
      itoa_pkg::ST_IDLE: accept    = in_valid_i;
      itoa_pkg::ST_CONV: conv_step = 1'b1;
      itoa_pkg::ST_EMIT: emit_beat = out_free && (total != '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itoa_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      dc_q        <= '0;
      rq_q        <= '0;
      pos_q       <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        rq_q  <= in_mag;
        pos_q <= '0;
        // zero value: one '0' digit unless precision is exactly zero
        if (in_mag == 32'd0 && !(in_prec_en && in_prec == '0)) begin
          dc_q <= DW'(1);
        end else begin
          dc_q <= '0;
        end
      end else if (conv_step) begin
        rq_q <= quot;
        dc_q <= dc_q + DW'(1);
      end else if (emit_beat) begin
        pos_q <= pos_q + CW'(1);
      end
      if (emit_beat) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      neg_q     <= in_neg;
      upper_q   <= in_upper;
      left_q    <= in_left;
      prec_en_q <= in_prec_en;
      prec_q    <= in_prec;
      fw_q      <= field_width_i;
      base_q    <= in_base;
    end
    if (emit_beat) begin
      out_char_q <= ch;
      last_q     <= is_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      digit_store[0] <= 4'd0;
    end else if (conv_step) begin
      digit_store[dc_q[AW-1:0]] <= rem;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// File: verif/itoa_format_checker.sv
// ----------------------------------------------------------------------------
// itoa_format_checker
// Watches both channels of the integer-to-ASCII formatter, builds the
// character beats each accepted item should produce and compares every
// output beat, field by field, with the oldest one still waiting.
// ----------------------------------------------------------------------------
module itoa_format_checker
  import itoa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [31:0]       value_i,
  input  logic [2:0]        action_i,
  input  logic [5:0]        field_width_i,
  input  logic signed [6:0] min_digits_i,
  input  logic              left_align_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [7:0]        out_char_i,
  input  logic              last_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                chars_checked_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  char_beat_t expected_chars[$];
  char_beat_t oldest_beat;

  initial begin
    fail_count_o    = 0;
    pending_o       = 0;
    chars_checked_o = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count_o++;
  endtask

  function automatic logic [7:0] digit_to_ascii(input logic [3:0] digit, input logic upper);
    logic [7:0] d8;
    d8 = {4'd0, digit};
    if (digit < 4'd10) begin
      return CH_ZERO + d8;
    end
    return (upper ? CH_UA : CH_LA) + d8 - 8'd10;
  endfunction

  // Appends the expected character beats of one item to expected_chars.
  function automatic void format_integer(
    input logic [31:0]       value,
    input logic [2:0]        action,
    input logic [5:0]        width,
    input logic signed [6:0] min_digits,
    input logic              left_align
  );
    logic [31:0] radix;
    logic [31:0] mag;
    logic [31:0] quot;
    logic        upper;
    logic        neg;
    logic        left;
    logic [3:0]  digit_buf[DIGIT_DEPTH];
    logic [7:0]  text[$];
    int          prec;
    int          ndig;
    int          zeros;
    int          body;
    int          pad;
    int          nout;
    char_beat_t  beat;

    radix = 32'd10;
    upper = 1'b0;
    left  = left_align;
    prec  = min_digits;
    case (action)
      ACT_OCT:  radix = 32'd8;
      ACT_HEXL: radix = 32'd16;
      ACT_HEXU: begin
        radix = 32'd16;
        upper = 1'b1;
      end
      ACT_BIN: begin
        radix = 32'd2;
        prec  = -1;
        left  = 1'b0;
      end
      default: ;  // signed/unsigned decimal and the spare codes
    endcase

    neg = (action == ACT_SDEC) && value[31];
    mag = neg ? 32'd0 - value : value;
    if (prec < 0) prec = -1;
    if (prec > int'(MAX_WIDTH) - 1) prec = int'(MAX_WIDTH) - 1;

    ndig = 0;
    quot = mag;
    if (mag == 32'd0) begin
      // zero with precision zero prints no digit at all
      if (prec != 0) begin
        digit_buf[0] = 4'd0;
        ndig = 1;
      end
    end else begin
      while (quot != 32'd0 && ndig < int'(DIGIT_DEPTH)) begin
        digit_buf[ndig] = 4'(quot % radix);
        quot = quot / radix;
        ndig++;
      end
    end

    zeros = (prec > ndig) ? prec - ndig : 0;
    body  = (neg ? 1 : 0) + zeros + ndig;
    pad   = (int'(width) > body) ? int'(width) - body : 0;

    if (!left) repeat (pad) text.push_back(CH_SPACE);
    if (neg) text.push_back(CH_MINUS);
    repeat (zeros) text.push_back(CH_ZERO);
    for (int i = ndig - 1; i >= 0; i--) text.push_back(digit_to_ascii(digit_buf[i], upper));
    if (left) repeat (pad) text.push_back(CH_SPACE);

    nout = (text.size() > int'(MAX_WIDTH)) ? int'(MAX_WIDTH) : text.size();
    for (int i = 0; i < nout; i++) begin
      beat.ch   = text[i];
      beat.last = (i == nout - 1);
      expected_chars.push_back(beat);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_chars.delete();
      pending_o = 0;
    end else begin
      // output side first: a beat leaving now belongs to an older item
      if (out_valid_i && !out_stall_i) begin
        chars_checked_o++;
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected beat char=0x%02h last=%0b",
                                    out_char_i, last_i));
        end else begin
          oldest_beat = expected_chars.pop_front();
          if (out_char_i !== oldest_beat.ch)
            report_mismatch($sformatf("out_char got 0x%02h want 0x%02h",
                                      out_char_i, oldest_beat.ch));
          if (last_i !== oldest_beat.last)
            report_mismatch($sformatf("last got %0b want %0b (char 0x%02h)",
                                      last_i, oldest_beat.last, oldest_beat.ch));
        end
      end
      if (in_valid_i && !in_stall_i)
        format_integer(value_i, action_i, field_width_i, min_digits_i, left_align_i);
      pending_o = expected_chars.size();
    end
  end

endmodule

// File: verif/integer_to_ascii_formatter_test.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_test
// Drives the formatter with directed corner items and then randomized items
// over every conversion kind, width, precision and justification, with random
// gaps on the input and random stalls on the output; a checker beside the
// block predicts and compares each character beat.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_test;

  timeunit 1ns;
  timeprecision 1ps;

  import itoa_pkg::*;

  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          RANDOM_ITEMS = 350;
  localparam int          DRAIN_CYCLES = 120;
  // codes outside the documented set decode as unsigned decimal
  localparam logic [2:0]  ACT_SPARE_A  = 3'd6;
  localparam logic [2:0]  ACT_SPARE_B  = 3'd7;
  localparam logic [6:0]  NO_PREC      = 7'h7F;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [31:0]       value;
  logic [2:0]        action;
  logic [5:0]        field_width;
  logic signed [6:0] min_digits;
  logic              left_align;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        out_char;
  logic              last;

  int fail_count;
  int pending;
  int chars_checked;
  int items_sent;
  int cycle_count;
  logic quiet;  // no gaps and no stalls while set

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  integer_to_ascii_formatter DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .value_i       (value),
    .action_i      (action),
    .field_width_i (field_width),
    .min_digits_i  (min_digits),
    .left_align_i  (left_align),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_char_o    (out_char),
    .last_o        (last)
  );

  itoa_format_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .value_i         (value),
    .action_i        (action),
    .field_width_i   (field_width),
    .min_digits_i    (min_digits),
    .left_align_i    (left_align),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_char_i      (out_char),
    .last_i          (last),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .chars_checked_o (chars_checked)
  );

  task automatic send_item(
    input logic [31:0] val,
    input logic [2:0]  act,
    input logic [5:0]  width,
    input logic [6:0]  prec,
    input logic        left
  );
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    value       <= val;
    action      <= act;
    field_width <= width;
    min_digits  <= prec;
    left_align  <= left;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // hold the input off until every outstanding character beat has come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_random_item();
    logic [31:0] val;
    logic [2:0]  act;
    logic [5:0]  width;
    logic [6:0]  prec;
    case ($urandom_range(0, 5))
      0: val = 32'd0;
      1: val = $urandom_range(0, 20);
      2: begin
        case ($urandom_range(0, 3))
          0: val = 32'h8000_0000;
          1: val = 32'h7FFF_FFFF;
          2: val = 32'hFFFF_FFFF;
          default: val = 32'h8000_0001;
        endcase
      end
      3: val = $urandom >> $urandom_range(0, 31);
      default: val = $urandom;
    endcase
    act   = ($urandom_range(0, 15) < 14) ? 3'($urandom_range(0, 5))
                                         : 3'($urandom_range(6, 7));
    width = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                        : 6'($urandom_range(0, 16));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: prec = NO_PREC;
      4:          prec = 7'd0;
      5, 6:       prec = 7'($urandom_range(0, 10));
      7:          prec = 7'($urandom_range(0, 63));
      8:          prec = 7'($urandom_range(0, 62));
      default:    prec = 7'($urandom_range(64, 126));  // negatives other than -1
    endcase
    send_item(val, act, width, prec, 1'($urandom_range(0, 1)));
  endtask

  // receiver: random stall ahead of every beat
  initial begin
    int hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      hold = quiet ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d beats still expected", cycle_count, pending);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    value       = 32'd0;
    action      = ACT_SDEC;
    field_width = 6'd0;
    min_digits  = NO_PREC;
    left_align  = 1'b0;
    items_sent  = 0;
    quiet       = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed corners
    send_item(32'd0,         ACT_SDEC,    6'd0,  NO_PREC, 1'b0);
    send_item(32'd0,         ACT_SDEC,    6'd0,  7'd0,    1'b0);  // nothing printed
    send_item(32'd0,         ACT_SDEC,    6'd5,  7'd0,    1'b0);  // padding only
    send_item(32'h8000_0000, ACT_SDEC,    6'd0,  NO_PREC, 1'b0);
    send_item(32'hFFFF_FFFF, ACT_SDEC,    6'd4,  7'd3,    1'b1);
    send_item(32'h7FFF_FFFF, ACT_SDEC,    6'd63, NO_PREC, 1'b0);
    send_item(32'hFFFF_FFFF, ACT_UDEC,    6'd0,  NO_PREC, 1'b0);
    send_item(32'hFFFF_FFFF, ACT_OCT,     6'd12, 7'd15,   1'b1);
    send_item(32'hDEAD_BEEF, ACT_HEXL,    6'd10, NO_PREC, 1'b0);
    send_item(32'hDEAD_BEEF, ACT_HEXU,    6'd0,  7'd62,   1'b0);
    send_item(32'd0,         ACT_BIN,     6'd0,  7'd0,    1'b0);  // binary ignores precision
    send_item(32'hFFFF_FFFF, ACT_BIN,     6'd40, 7'd10,   1'b1);  // and left justify
    send_item(32'h8000_0000, ACT_BIN,     6'd63, NO_PREC, 1'b0);
    send_item(32'd12345,     ACT_SPARE_A, 6'd8,  NO_PREC, 1'b0);
    send_item(32'hFFFF_FFFF, ACT_SPARE_B, 6'd0,  NO_PREC, 1'b1);
    send_item(32'h8000_0001, ACT_SDEC,    6'd0,  7'd62,   1'b0);  // 63 characters
    send_item(32'd42,        ACT_SDEC,    6'd10, 7'h7B,   1'b1);  // precision -5
    send_item(32'd0,         ACT_UDEC,    6'd63, 7'h40,   1'b1);  // precision -64
    send_item(32'd255,       ACT_HEXL,    6'd1,  7'd0,    1'b0);
    send_item(32'd7,         ACT_UDEC,    6'd6,  7'd63,   1'b0);  // saturating precision
    send_item(32'd0,         ACT_OCT,     6'd0,  7'd0,    1'b1);
    send_item(32'd0,         ACT_HEXU,    6'd3,  7'd0,    1'b1);
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 150 && n < 200);
      if (n == 100 || n == 250) wait_drained();
      send_random_item();
    end
    quiet = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d items over all conversion kinds, widths 0..63, precisions and",
             items_sent);
    $display("justifications; %0d character beats checked under random gaps and stalls.",
             chars_checked);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
